[rtl/adpt_pkg.sv]
package adpt_pkg;

    // Input command codes
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_PREPARE = 2'd1;
    localparam logic [1:0] KIND_START   = 2'd2;
    localparam logic [1:0] KIND_STOP    = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_IS_PLAYBACK     = 3'd0;
    localparam logic [2:0] REG_FRAMES_PER_TICK = 3'd1;
    localparam logic [2:0] REG_PERIOD_FRAMES   = 3'd2;
    localparam logic [2:0] REG_BUFFER_FRAMES   = 3'd3;
    localparam logic [2:0] REG_BOUNDARY_FRAMES = 3'd4;

    // Divider operand selection
    localparam logic [1:0] DIV_POS = 2'd0;   // buffer position mod boundary
    localparam logic [1:0] DIV_PER = 2'd1;   // period accumulator mod period
    localparam logic [1:0] DIV_HW  = 2'd2;   // buffer position mod buffer size

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 31;
    localparam int POS_W       = 30;
    localparam int DIV_W       = 31;
    localparam int SIZE_W      = 17;
    localparam int PTR_W       = 16;

    localparam logic [SIZE_W-1:0] SIZE_LIMIT = 17'd65536;
    localparam logic [DIV_W-1:0]  POS_LIMIT  = 31'd1073741824;

    typedef struct packed {
        logic [1:0]       kind;
        logic [POS_W-1:0] appl_position;
    } in_item_t;

    typedef struct packed {
        logic [PTR_W-1:0] hw_pointer;
        logic             period_elapsed;
    } out_item_t;

    typedef struct packed {
        logic       latch_in;
        logic       clear_pos;
        logic       set_run;
        logic       clr_run;
        logic       clr_elapsed;
        logic       load_dist;
        logic       load_adv;
        logic       load_acc;
        logic       div_start;
        logic [1:0] div_sel;
        logic       load_bp;
        logic       load_pp_acc;
        logic       load_pp_rem;
        logic       set_elapsed;
        logic       load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       running;
        logic       div_done;
        logic       acc_ge_per;
        logic       slot_free;
    } dp_status_t;

    // Zero acts as one, oversize clamps to the limit
    function automatic logic [SIZE_W-1:0] size_eff(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
            r = {{(SIZE_W-1){1'b0}}, 1'b1};
        else if (v > SIZE_LIMIT)
            r = SIZE_LIMIT;
        return r;
    endfunction

    // Zero or oversize boundary acts as the full position range
    function automatic logic [DIV_W-1:0] boundary_eff(input logic [DIV_W-1:0] v);
        logic [DIV_W-1:0] r;
        r = v;
        if (v == '0 || v > POS_LIMIT)
            r = POS_LIMIT;
        return r;
    endfunction

endpackage

[rtl/adpt_remdiv.sv]
module adpt_remdiv (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [adpt_pkg::DIV_W-1:0] dividend,
    input  logic [adpt_pkg::DIV_W-1:0] divisor,
    output logic                      done,
    output logic [adpt_pkg::DIV_W-1:0] rem
);
    import adpt_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] dvd_reg;
    logic [DIV_W-1:0] dsr_reg;
    logic [DIV_W-1:0] rem_reg;

    logic [DIV_W:0]   trial;
    logic [DIV_W-1:0] rem_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DIV_W-1]};
        if (trial >= {1'b0, dsr_reg})
            rem_next = DIV_W'(trial - {1'b0, dsr_reg});
        else
            rem_next = trial[DIV_W-1:0];
    end

    // Control: step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= LAST_STEP;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Operand and partial remainder registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dsr_reg))
        else $error("remainder not below divisor");

    a_no_start_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

[rtl/adpt_datapath.sv]
module adpt_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [adpt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [adpt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  adpt_pkg::in_item_t              in_data,
    output adpt_pkg::out_item_t             out_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    input  adpt_pkg::ctrl_cmd_t             cmd,
    output adpt_pkg::dp_status_t            status
);
    import adpt_pkg::*;

    // Configuration
    logic              is_playback_reg;
    logic [15:0]       fpt_reg;
    logic [SIZE_W-1:0] period_reg;
    logic [SIZE_W-1:0] buffer_reg;
    logic [DIV_W-1:0]  boundary_reg;

    // Block state
    logic              running_reg;
    logic [POS_W-1:0]  bp_reg;
    logic [15:0]       pp_reg;

    // Working registers
    logic [1:0]        kind_reg;
    logic [POS_W-1:0]  appl_reg;
    logic [DIV_W-1:0]  dist_reg;
    logic [15:0]       adv_reg;
    logic [SIZE_W-1:0] acc_reg;
    logic              elapsed_reg;
    out_item_t         out_reg;
    logic              out_valid_reg;

    logic [SIZE_W-1:0] per_eff;
    logic [SIZE_W-1:0] buf_eff;
    logic [DIV_W-1:0]  bnd_eff;
    logic [DIV_W-1:0]  dist_next;
    logic [31:0]       wrap_dist;
    logic [15:0]       adv_next;
    logic [SIZE_W-1:0] acc_next;
    logic [DIV_W-1:0]  pos_sum;
    logic [DIV_W-1:0]  div_dividend;
    logic [DIV_W-1:0]  div_divisor;
    logic              div_done;
    logic [DIV_W-1:0]  div_rem;
    logic              out_valid_next;

    assign per_eff = size_eff(period_reg);
    assign buf_eff = size_eff(buffer_reg);
    assign bnd_eff = boundary_eff(boundary_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_playback_reg <= 1'b1;
            fpt_reg         <= 16'd480;
            period_reg      <= 17'd1024;
            buffer_reg      <= 17'd4096;
            boundary_reg    <= POS_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IS_PLAYBACK:     is_playback_reg <= cfg_data[0];
                REG_FRAMES_PER_TICK: fpt_reg         <= cfg_data[15:0];
                REG_PERIOD_FRAMES:   period_reg      <= cfg_data[SIZE_W-1:0];
                REG_BUFFER_FRAMES:   buffer_reg      <= cfg_data[SIZE_W-1:0];
                REG_BOUNDARY_FRAMES: boundary_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Distance to the application pointer, then wrap and clamp
    assign dist_next = {1'b0, appl_reg} - {1'b0, bp_reg};

    always_comb
    begin
        if (dist_reg[DIV_W-1])
            wrap_dist = {dist_reg[DIV_W-1], dist_reg} + {1'b0, bnd_eff};
        else
            wrap_dist = {1'b0, dist_reg};

        if (!is_playback_reg)
            adv_next = fpt_reg;
        else if (wrap_dist[31] || (wrap_dist[30:0] > {15'b0, fpt_reg}))
            adv_next = fpt_reg;
        else
            adv_next = wrap_dist[15:0];
    end

    assign acc_next = {1'b0, pp_reg} + {1'b0, adv_reg};
    assign pos_sum  = {1'b0, bp_reg} + {15'b0, adv_reg};

    // Divider operand selection
    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_POS:
            begin
                div_dividend = pos_sum;
                div_divisor  = bnd_eff;
            end
            DIV_PER:
            begin
                div_dividend = {14'b0, acc_reg};
                div_divisor  = {14'b0, per_eff};
            end
            default:
            begin
                div_dividend = {1'b0, bp_reg};
                div_divisor  = {14'b0, buf_eff};
            end
        endcase
    end

    adpt_remdiv u_remdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .rem      (div_rem)
    );

    // Position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            bp_reg      <= '0;
            pp_reg      <= '0;
        end
        else
        begin
            if (cmd.set_run)
                running_reg <= 1'b1;
            else if (cmd.clr_run)
                running_reg <= 1'b0;

            if (cmd.clear_pos)
                bp_reg <= '0;
            else if (cmd.load_bp)
                bp_reg <= div_rem[POS_W-1:0];

            if (cmd.clear_pos)
                pp_reg <= '0;
            else if (cmd.load_pp_acc)
                pp_reg <= acc_reg[15:0];
            else if (cmd.load_pp_rem)
                pp_reg <= div_rem[15:0];
        end
    end

    // Request capture and intermediate values
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            kind_reg <= in_data.kind;
            appl_reg <= in_data.appl_position;
        end
        if (cmd.load_dist)
            dist_reg <= dist_next;
        if (cmd.load_adv)
            adv_reg <= adv_next;
        if (cmd.load_acc)
            acc_reg <= acc_next;
        if (cmd.clr_elapsed)
            elapsed_reg <= 1'b0;
        else if (cmd.set_elapsed)
            elapsed_reg <= 1'b1;
        if (cmd.load_out)
        begin
            out_reg.hw_pointer     <= div_rem[PTR_W-1:0];
            out_reg.period_elapsed <= elapsed_reg;
        end
    end

    // Output slot
    assign out_valid_next = cmd.load_out | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

    assign status.kind       = kind_reg;
    assign status.running    = running_reg;
    assign status.div_done   = div_done;
    assign status.acc_ge_per = (acc_reg >= per_eff);
    assign status.slot_free  = !out_valid_reg || out_ready;

    a_load_only_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result written over a pending result");

endmodule

[rtl/adpt_ctrl.sv]
module adpt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  adpt_pkg::dp_status_t status,
    output adpt_pkg::ctrl_cmd_t  cmd
);
    import adpt_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CMD       = 4'd1;
    localparam logic [3:0] S_DIST      = 4'd2;
    localparam logic [3:0] S_ADV       = 4'd3;
    localparam logic [3:0] S_POS_ISSUE = 4'd4;
    localparam logic [3:0] S_POS_WAIT  = 4'd5;
    localparam logic [3:0] S_PER_ISSUE = 4'd6;
    localparam logic [3:0] S_PER_WAIT  = 4'd7;
    localparam logic [3:0] S_HW_ISSUE  = 4'd8;
    localparam logic [3:0] S_HW_WAIT   = 4'd9;
    localparam logic [3:0] S_OUT       = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
                if (in_valid)
                    state_next = S_CMD;
            end
            S_CMD:
            begin
                cmd.clr_elapsed = 1'b1;
                state_next      = S_HW_ISSUE;
                unique case (status.kind)
                    KIND_TICK:
                    begin
                        if (status.running)
                            state_next = S_DIST;
                    end
                    KIND_PREPARE: cmd.clear_pos = 1'b1;
                    KIND_START:   cmd.set_run   = 1'b1;
                    default:      cmd.clr_run   = 1'b1;
                endcase
            end
            S_DIST:
            begin
                cmd.load_dist = 1'b1;
                state_next    = S_ADV;
            end
            S_ADV:
            begin
                cmd.load_adv = 1'b1;
                state_next   = S_POS_ISSUE;
            end
            S_POS_ISSUE:
            begin
                cmd.div_sel   = DIV_POS;
                cmd.div_start = 1'b1;
                cmd.load_acc  = 1'b1;
                state_next    = S_POS_WAIT;
            end
            S_POS_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.load_bp = 1'b1;
                    if (status.acc_ge_per)
                    begin
                        cmd.set_elapsed = 1'b1;
                        state_next      = S_PER_ISSUE;
                    end
                    else
                    begin
                        cmd.load_pp_acc = 1'b1;
                        state_next      = S_HW_ISSUE;
                    end
                end
            end
            S_PER_ISSUE:
            begin
                cmd.div_sel   = DIV_PER;
                cmd.div_start = 1'b1;
                state_next    = S_PER_WAIT;
            end
            S_PER_WAIT:
            begin
                cmd.div_sel = DIV_PER;
                if (status.div_done)
                begin
                    cmd.load_pp_rem = 1'b1;
                    state_next      = S_HW_ISSUE;
                end
            end
            S_HW_ISSUE:
            begin
                cmd.div_sel   = DIV_HW;
                cmd.div_start = 1'b1;
                state_next    = S_HW_WAIT;
            end
            S_HW_WAIT:
            begin
                cmd.div_sel = DIV_HW;
                if (status.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.div_sel = DIV_HW;
                if (status.slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_done_only_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == S_POS_WAIT || state_reg == S_PER_WAIT
                             || state_reg == S_HW_WAIT))
        else $error("divider finished outside a wait state");

endmodule

[rtl/audio_dma_position_tracker.sv]
// Work per request: prepare, start, stop and stopped ticks compute one remainder
// (the hardware pointer); a running tick computes two, three when it completes a period.
// Throughput: one request at a time; each remainder runs on one shared
// restoring divider that retires one bit per cycle.
// Reset: asynchronous active low; stopped, positions zero, registers at defaults.
module audio_dma_position_tracker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [adpt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [adpt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  adpt_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output adpt_pkg::out_item_t             out_data
);
    import adpt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    adpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    adpt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

[sim/tb_top.sv]
module tb_top;

    import adpt_pkg::*;

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int HOLD_CYCLES     = 400;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int BURST_ITEMS     = 30;
    localparam int MAX_PRINTS      = 40;

    // Index with no register behind it; writes must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_data;

    audio_dma_position_tracker u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Predictor copy of the registers
    logic              c_playback = 1'b1;
    logic [15:0]       c_fpt      = 16'd480;
    logic [16:0]       c_period   = 17'd1024;
    logic [16:0]       c_buffer   = 17'd4096;
    logic [30:0]       c_boundary = POS_LIMIT;

    // Predictor copy of the pointer state
    logic              m_running    = 1'b0;
    logic [15:0]       m_period_pos = '0;
    logic [POS_W-1:0]  m_buffer_pos = '0;

    out_item_t         pending_pointers[$];
    out_item_t         head_pointer;
    int                mismatches     = 0;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                hold_left      = 0;
    int                quiet_cycles   = 0;

    // Zero acts as one, oversize clamps
    function automatic longint clamp_size(input logic [16:0] v);
        if (v == '0)
            return 1;
        if (v > SIZE_LIMIT)
            return SIZE_LIMIT;
        return v;
    endfunction

    // Zero or oversize boundary means the full position range
    function automatic longint wrap_point(input logic [30:0] v);
        if (v == '0 || v > POS_LIMIT)
            return POS_LIMIT;
        return v;
    endfunction

    // Apply one request to the predicted state and return the expected result
    function automatic out_item_t predict_pointer(input in_item_t req);
        out_item_t res;
        longint    bnd;
        longint    gap;
        longint    adv;
        longint    acc;
        longint    per;
        longint    pos;
        longint    fpt;
        res.period_elapsed = 1'b0;
        case (req.kind)
            KIND_TICK:
            begin
                if (m_running)
                begin
                    bnd = wrap_point(c_boundary);
                    fpt = c_fpt;
                    pos = m_buffer_pos;
                    if (!c_playback)
                        adv = fpt;
                    else
                    begin
                        gap = req.appl_position;
                        gap = gap - pos;
                        if (gap < 0)
                            gap = gap + bnd;
                        adv = (gap < 0 || gap > fpt) ? fpt : gap;
                    end
                    per = clamp_size(c_period);
                    acc = m_period_pos;
                    acc = acc + adv;
                    m_buffer_pos = POS_W'((pos + adv) % bnd);
                    if (acc >= per)
                    begin
                        acc = acc % per;
                        res.period_elapsed = 1'b1;
                    end
                    m_period_pos = 16'(acc);
                end
            end
            KIND_PREPARE:
            begin
                m_period_pos = '0;
                m_buffer_pos = '0;
            end
            KIND_START: m_running = 1'b1;
            default:    m_running = 1'b0;
        endcase
        pos = m_buffer_pos;
        res.hw_pointer = PTR_W'(pos % clamp_size(c_buffer));
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 75; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            IDLE_BOTH:     begin send_idle_pct = 12; recv_stall_pct = 12; end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Register write; only called with nothing in flight
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_IS_PLAYBACK:     c_playback = val[0];
            REG_FRAMES_PER_TICK: c_fpt      = val[15:0];
            REG_PERIOD_FRAMES:   c_period   = val[16:0];
            REG_BUFFER_FRAMES:   c_buffer   = val[16:0];
            REG_BOUNDARY_FRAMES: c_boundary = val[30:0];
            default: ;
        endcase
    endtask

    // Offer one request; returns at the edge that accepts it, valid still high
    task automatic issue_request(input logic [1:0] kind, input logic [POS_W-1:0] appl);
        in_item_t req;
        req.kind          = kind;
        req.appl_position = appl;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_pointers.push_back(predict_pointer(req));
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pointers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Application pointer: mostly close to the predicted position
    function automatic logic [POS_W-1:0] pick_appl();
        longint bnd;
        longint off;
        longint a;
        logic [31:0] raw;
        raw = $urandom();
        if (c_playback && $urandom_range(9) < 7)
        begin
            bnd = wrap_point(c_boundary);
            off = $urandom_range(0, c_fpt + c_fpt / 8 + 2);
            if ($urandom_range(9) == 0)
                off = -longint'($urandom_range(1, 64));
            a = m_buffer_pos;
            a = ((a + off) % bnd + bnd) % bnd;
            return a[POS_W-1:0];
        end
        return raw[POS_W-1:0];
    endfunction

    function automatic logic [16:0] pick_size();
        logic [16:0] s;
        case ($urandom_range(9))
            0:       s = '0;
            1:       s = 17'd1;
            2:       s = 17'h1FFFF;
            3:       s = SIZE_LIMIT;
            4, 5:    s = 17'($urandom_range(1, 64));
            default: s = 17'($urandom_range(1, 4096));
        endcase
        return s;
    endfunction

    function automatic logic [15:0] pick_fpt();
        logic [15:0] f;
        case ($urandom_range(9))
            0:          f = '0;
            1:          f = 16'd1;
            2:          f = 16'hFFFF;
            3, 4, 5:    f = 16'($urandom_range(1, 600));
            default:    f = 16'($urandom_range(0, 65535));
        endcase
        return f;
    endfunction

    function automatic logic [30:0] pick_boundary(input logic [16:0] bufsz);
        logic [30:0] b;
        case ($urandom_range(9))
            0:       b = '0;
            1:       b = POS_LIMIT;
            2:       b = 31'h7FFFFFFF;
            default: b = 31'(clamp_size(bufsz) * $urandom_range(1, 64));
        endcase
        return b;
    endfunction

    // Commands and playback distances at the reset settings
    task automatic test_command_sequence();
        set_idling(IDLE_NONE);
        issue_request(KIND_TICK, 30'h3FFFFFFF);     // tick while stopped
        issue_request(KIND_STOP, '0);               // stop while stopped
        issue_request(KIND_START, '0);
        issue_request(KIND_START, '0);              // start while running
        issue_request(KIND_TICK, '0);               // zero distance
        issue_request(KIND_TICK, 30'd100);          // distance inside the clamp
        issue_request(KIND_TICK, 30'h3FFFFFFF);     // far ahead, clamped
        issue_request(KIND_TICK, 30'd50);           // behind, wraps via boundary
        issue_request(KIND_PREPARE, 30'h15555555);  // prepare while running
        issue_request(KIND_TICK, 30'h2AAAAAAA);
        issue_request(KIND_STOP, '0);
        issue_request(KIND_TICK, 30'd7);
        drain_results();
    endtask

    // Zero and oversize registers, shrinking sizes under live positions
    task automatic test_register_extremes();
        set_idling(IDLE_NONE);
        write_reg(REG_FRAMES_PER_TICK, 31'h0000FFFF);
        write_reg(REG_PERIOD_FRAMES, '0);
        write_reg(REG_BUFFER_FRAMES, '0);
        write_reg(REG_BOUNDARY_FRAMES, '0);
        issue_request(KIND_PREPARE, '0);
        issue_request(KIND_START, '0);
        issue_request(KIND_TICK, 30'd70000);
        issue_request(KIND_TICK, 30'd65635);
        drain_results();
        write_reg(REG_PERIOD_FRAMES, 31'h0001FFFF);
        write_reg(REG_BUFFER_FRAMES, 31'h0001FFFF);
        write_reg(REG_BOUNDARY_FRAMES, 31'h7FFFFFFF);
        issue_request(KIND_TICK, 30'h3FFFFFFF);
        issue_request(KIND_TICK, pick_appl());
        drain_results();
        // boundary now below the position: pointer stays behind after wrap
        write_reg(REG_BOUNDARY_FRAMES, 31'd1000);
        issue_request(KIND_TICK, '0);
        issue_request(KIND_TICK, 30'd500);
        drain_results();
        write_reg(REG_IS_PLAYBACK, '0);
        write_reg(REG_FRAMES_PER_TICK, '0);
        write_reg(REG_PERIOD_FRAMES, 31'd1);
        write_reg(REG_BUFFER_FRAMES, 31'd1);
        write_reg(REG_UNUSED, 31'h7FFFFFFF);
        issue_request(KIND_TICK, '0);
        drain_results();
        write_reg(REG_FRAMES_PER_TICK, 31'd1);
        issue_request(KIND_TICK, 30'h3FFFFFFF);
        issue_request(KIND_TICK, '0);
        issue_request(KIND_STOP, '0);
        drain_results();
    endtask

    // Receiver holds off while requests keep coming
    task automatic test_output_backpressure();
        write_reg(REG_IS_PLAYBACK, 31'd1);
        write_reg(REG_FRAMES_PER_TICK, 31'd480);
        write_reg(REG_PERIOD_FRAMES, 31'd1024);
        write_reg(REG_BUFFER_FRAMES, 31'd4096);
        write_reg(REG_BOUNDARY_FRAMES, POS_LIMIT);
        set_idling(IDLE_NONE);
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        issue_request(KIND_START, '0);
        for (int i = 1; i < BURST_ITEMS; i++)
            issue_request(KIND_TICK, pick_appl());
        drain_results();
    endtask

    // Random settings per phase, mostly running ticks
    task automatic test_random_phases();
        logic [16:0] bufsz;
        logic [1:0]  kind;
        int          r;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            bufsz = pick_size();
            write_reg(REG_IS_PLAYBACK, 31'((ph % 3) != 0));
            write_reg(REG_FRAMES_PER_TICK, 31'(pick_fpt()));
            write_reg(REG_PERIOD_FRAMES, 31'(pick_size()));
            write_reg(REG_BUFFER_FRAMES, 31'(bufsz));
            write_reg(REG_BOUNDARY_FRAMES, pick_boundary(bufsz));
            set_idling(idle_mode_t'(ph % 4));
            issue_request(KIND_PREPARE, pick_appl());
            issue_request(KIND_START, pick_appl());
            for (int i = 2; i < ITEMS_PER_PHASE; i++)
            begin
                r = $urandom_range(99);
                if (r < 80)
                    kind = KIND_TICK;
                else if (r < 86)
                    kind = KIND_PREPARE;
                else if (r < 96)
                    kind = KIND_START;
                else
                    kind = KIND_STOP;
                issue_request(kind, pick_appl());
            end
        end
        drain_results();
        set_idling(IDLE_NONE);
    endtask

    // Receiver: random stalls plus the long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result check against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pointers.size() == 0)
                report_mismatch($sformatf("result with none pending, hw_pointer %0d",
                                          out_data.hw_pointer));
            else
            begin
                head_pointer = pending_pointers.pop_front();
                if (out_data.hw_pointer !== head_pointer.hw_pointer)
                    report_mismatch($sformatf("hw_pointer %0d, predicted %0d",
                                              out_data.hw_pointer, head_pointer.hw_pointer));
                if (out_data.period_elapsed !== head_pointer.period_elapsed)
                    report_mismatch($sformatf("period_elapsed %0b, predicted %0b",
                                              out_data.period_elapsed,
                                              head_pointer.period_elapsed));
            end
        end
    end

    // Cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        @(posedge clk);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_command_sequence();
        test_register_extremes();
        test_output_backpressure();
        test_random_phases();
        drain_results();
        repeat (150) @(posedge clk);
        if (mismatches == 0 && pending_pointers.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[audio_dma_position_tracker.f]
rtl/adpt_pkg.sv
rtl/adpt_remdiv.sv
rtl/adpt_datapath.sv
rtl/adpt_ctrl.sv
rtl/audio_dma_position_tracker.sv
sim/tb_top.sv
